>>> design/spectral_bin_cross_modulator_core_assert.svh
// Assertion macros used by the spectral bin cross-modulator RTL.
`ifndef SPECTRAL_BIN_CROSS_MODULATOR_CORE_ASSERT_SVH
`define SPECTRAL_BIN_CROSS_MODULATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBCM_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SBCM_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

>>> design/sbcm_pkg.sv
// Types and constants of the spectral bin cross-modulator.
package sbcm_pkg;

  localparam int FFT_POINTS = 1024;
  localparam int BIN_COUNT  = FFT_POINTS / 2 + 1;
  localparam int ADDR_W     = $clog2(BIN_COUNT);

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 20;

  // Pipeline positions, counted in edges after the input register.
  localparam int K_A = 2 + SQRT_STAGES;
  localparam int K_C = K_A + 2;
  localparam int K_G = K_C + DIV_STAGES;
  localparam int K_H = K_G + 1;
  localparam int K_P = K_H + 1;

  localparam logic [13:0] SMOOTH_A = 14'd9830;
  localparam logic [15:0] SMOOTH_B = 16'd55706;
  localparam logic [19:0] GAIN_ONE = 20'h10000;
  localparam logic [19:0] ENV_MAX  = 20'h80000;

  localparam logic [2:0] MODE_RING  = 3'd0;
  localparam logic [2:0] MODE_AMP   = 3'd1;
  localparam logic [2:0] MODE_CROSS = 3'd2;
  localparam logic [2:0] MODE_AM    = 3'd3;
  localparam logic [2:0] MODE_SUB   = 3'd4;
  localparam logic [2:0] MODE_MIN   = 3'd5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd2;

  typedef struct packed {
    logic        [9:0]  bin_index;
    logic signed [31:0] carrier_re;
    logic signed [31:0] carrier_im;
    logic signed [31:0] mod_re;
    logic signed [31:0] mod_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
  } out_beat_t;

  typedef struct packed {
    logic        [9:0]  bin;
    logic signed [31:0] cre;
    logic signed [31:0] cim;
  } side_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [45:0]       mterm;
  } smooth_req_t;

endpackage

>>> design/spectral_bin_cross_modulator_core.sv
// Spectral bin cross-modulator: top level.
//
// One FFT bin per clock goes in while in_stall is low, and one bin comes out for
// each; the whole pipeline advances together and stalls only while the output
// beat is held. Its depth is mostly the two 32-stage square-root pipelines
// (carrier and modulator magnitude) and the 20-stage envelope divider; the per-bin
// smoothing runs as a read-modify-write on a 513-entry memory, with forwarding for
// back-to-back beats of the same bin. After reset the smoothing memory is cleared
// entry by entry, with in_stall high until the clear is done. Configuration writes
// are taken at any time and should be made while no bin is in flight.
`include "spectral_bin_cross_modulator_core_assert.svh"

module spectral_bin_cross_modulator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbcm_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbcm_pkg::out_beat_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic adv;
  logic accept;
  logic busy;

  logic [2:0] mode_r;
  logic [9:0] band_low_r;
  logic [9:0] band_high_r;

  logic               vld_line [sbcm_pkg::K_P+1];
  sbcm_pkg::side_t    side_line[sbcm_pkg::K_P+1];
  logic signed [31:0] mod_re_r;
  logic signed [31:0] mod_im_r;

  logic signed [63:0] sq_mr_r, sq_mi_r, sq_cr_r, sq_ci_r;
  logic [63:0]        rad_m_r, rad_c_r;
  logic [31:0]        mroot, croot;

  sbcm_pkg::smooth_req_t req;
  logic [31:0]           ymag;
  logic [31:0]           xmag_line [2];
  logic [31:0]           ymag_line [sbcm_pkg::DIV_STAGES];
  logic [19:0]           env;

  logic [19:0] gain;
  logic [20:0] am_sum;
  logic        in_band;
  logic [19:0] gain_r;
  logic        proc_h_r;
  logic        proc_p_r;

  logic signed [52:0] prod_re_r, prod_im_r;
  logic               out_vld_r;
  sbcm_pkg::out_beat_t out_r;

  function automatic logic signed [31:0] round_sat(input logic signed [52:0] p);
    logic signed [52:0] r;
    logic signed [36:0] q;
    r = p + 53'sd32768;
    q = 37'(r >>> 16);
    if (q > 37'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (q < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  // Hold the whole pipeline while the output beat waits.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv || busy;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sbcm_pkg::MODE_RING;
      band_low_r  <= 10'd0;
      band_high_r <= 10'd460;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbcm_pkg::REG_MODE:      mode_r      <= cfg_data[2:0];
        sbcm_pkg::REG_BAND_LOW:  band_low_r  <= cfg_data[9:0];
        sbcm_pkg::REG_BAND_HIGH: band_high_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Valid line and side payload move with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= sbcm_pkg::K_P; k++) begin
        vld_line[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_line[0] <= accept;
      for (int k = 1; k <= sbcm_pkg::K_P; k++) begin
        vld_line[k] <= vld_line[k-1];
      end
      out_vld_r <= vld_line[sbcm_pkg::K_P];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_line[0].bin <= in_data.bin_index;
      side_line[0].cre <= in_data.carrier_re;
      side_line[0].cim <= in_data.carrier_im;
      mod_re_r         <= in_data.mod_re;
      mod_im_r         <= in_data.mod_im;
      for (int k = 1; k <= sbcm_pkg::K_P; k++) begin
        side_line[k] <= side_line[k-1];
      end
      sq_mr_r <= mod_re_r * mod_re_r;
      sq_mi_r <= mod_im_r * mod_im_r;
      sq_cr_r <= side_line[0].cre * side_line[0].cre;
      sq_ci_r <= side_line[0].cim * side_line[0].cim;
      rad_m_r <= 64'(sq_mr_r) + 64'(sq_mi_r);
      rad_c_r <= 64'(sq_cr_r) + 64'(sq_ci_r);
    end
  end

  sbcm_sqrt_pipe u_sqrt_mod (
    .clk      (clk),
    .en       (adv),
    .radicand (rad_m_r),
    .root     (mroot)
  );

  sbcm_sqrt_pipe u_sqrt_car (
    .clk      (clk),
    .en       (adv),
    .radicand (rad_c_r),
    .root     (croot)
  );

  // Bins beyond the store pass through and touch no entry.
  always_comb begin
    req.vld   = vld_line[sbcm_pkg::K_A] &&
                ({22'd0, side_line[sbcm_pkg::K_A].bin} < sbcm_pkg::BIN_COUNT);
    req.addr  = req.vld ? sbcm_pkg::ADDR_W'(side_line[sbcm_pkg::K_A].bin) : '0;
    req.mterm = mroot * sbcm_pkg::SMOOTH_A;
  end

  sbcm_smooth_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .req   (req),
    .ymag  (ymag),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      xmag_line[0] <= croot;
      xmag_line[1] <= xmag_line[0];
      ymag_line[0] <= ymag;
      for (int k = 1; k < sbcm_pkg::DIV_STAGES; k++) begin
        ymag_line[k] <= ymag_line[k-1];
      end
    end
  end

  sbcm_div_pipe u_div (
    .clk (clk),
    .en  (adv),
    .num (ymag),
    .den (xmag_line[1]),
    .env (env)
  );

  always_comb begin
    am_sum = {1'b0, env} + {1'b0, sbcm_pkg::GAIN_ONE};
    case (mode_r)
      sbcm_pkg::MODE_RING: begin
        gain = (ymag_line[sbcm_pkg::DIV_STAGES-1] < {12'd0, sbcm_pkg::GAIN_ONE}) ?
               ymag_line[sbcm_pkg::DIV_STAGES-1][19:0] : sbcm_pkg::GAIN_ONE;
      end
      sbcm_pkg::MODE_AMP, sbcm_pkg::MODE_MIN: begin
        gain = (env < sbcm_pkg::GAIN_ONE) ? env : sbcm_pkg::GAIN_ONE;
      end
      sbcm_pkg::MODE_CROSS: gain = env;
      sbcm_pkg::MODE_AM: begin
        gain = (am_sum > {1'b0, sbcm_pkg::ENV_MAX}) ? sbcm_pkg::ENV_MAX : am_sum[19:0];
      end
      sbcm_pkg::MODE_SUB: begin
        gain = (env < sbcm_pkg::GAIN_ONE) ? sbcm_pkg::GAIN_ONE - env : '0;
      end
      default: gain = sbcm_pkg::GAIN_ONE;
    endcase
  end

  assign in_band = ({22'd0, side_line[sbcm_pkg::K_G].bin} < sbcm_pkg::BIN_COUNT) &&
                   (side_line[sbcm_pkg::K_G].bin >= band_low_r) &&
                   (side_line[sbcm_pkg::K_G].bin <= band_high_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      gain_r    <= gain;
      proc_h_r  <= in_band;
      proc_p_r  <= proc_h_r;
      prod_re_r <= side_line[sbcm_pkg::K_H].cre * $signed({1'b0, gain_r});
      prod_im_r <= side_line[sbcm_pkg::K_H].cim * $signed({1'b0, gain_r});
      if (proc_p_r) begin
        out_r.out_re <= round_sat(prod_re_r);
        out_r.out_im <= round_sat(prod_im_r);
      end else begin
        out_r.out_re <= side_line[sbcm_pkg::K_P].cre;
        out_r.out_im <= side_line[sbcm_pkg::K_P].cim;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `SBCM_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, busy, in_stall)
  `SBCM_ASSERT_IMP(a_clear_pipe_empty, clk, rst_n, busy, !vld_line[sbcm_pkg::K_A])
  `SBCM_ASSERT_NXT(a_accept_enters, clk, rst_n, accept, vld_line[0])
  `SBCM_ASSERT_NXT(a_last_stage_out, clk, rst_n, adv && vld_line[sbcm_pkg::K_P], out_valid)

endmodule

>>> design/sbcm_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
module sbcm_sqrt_pipe (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [33:0] rem_r  [sbcm_pkg::SQRT_STAGES];
  logic [31:0] root_r [sbcm_pkg::SQRT_STAGES];
  logic [63:0] rad_r  [sbcm_pkg::SQRT_STAGES-1];

  for (genvar j = 0; j < sbcm_pkg::SQRT_STAGES; j++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [35:0] t;
    logic [35:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    assign t     = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem_r[j]  <= 34'(t - trial);
          root_r[j] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[j]  <= t[33:0];
          root_r[j] <= {root_in[30:0], 1'b0};
        end
      end
    end

    if (j < sbcm_pkg::SQRT_STAGES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[j] <= {rad_in[61:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[sbcm_pkg::SQRT_STAGES-1];

endmodule

>>> design/sbcm_div_pipe.sv
// Pipelined envelope divider: (num << 16) / den, clamped to 8.0.
module sbcm_div_pipe (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [19:0] env
);

  localparam int LAST = sbcm_pkg::DIV_STAGES - 1;

  logic        ovf_r [sbcm_pkg::DIV_STAGES];
  logic [32:0] rem_r [sbcm_pkg::DIV_STAGES];
  logic [2:0]  lo_r  [sbcm_pkg::DIV_STAGES];
  logic [31:0] d_r   [sbcm_pkg::DIV_STAGES];
  logic [18:0] q_r   [sbcm_pkg::DIV_STAGES];

  // A quotient of 8.0 or more (and a zero divisor) clamps at once.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= {3'b000, num} >= {den, 3'b000};
      rem_r[0] <= {4'b0000, num[31:3]};
      lo_r[0]  <= num[2:0];
      d_r[0]   <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i < sbcm_pkg::DIV_STAGES; i++) begin : g_stage
    localparam int B = sbcm_pkg::DIV_STAGES - 1 - i;
    logic        nb;
    logic [33:0] t;
    logic [33:0] dx;

    if (B >= 16) begin : g_num_bit
      assign nb = lo_r[i-1][B-16];
    end else begin : g_zero_bit
      assign nb = 1'b0;
    end

    assign t  = {rem_r[i-1], nb};
    assign dx = {2'b00, d_r[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= dx) begin
          rem_r[i] <= 33'(t - dx);
          q_r[i]   <= {q_r[i-1][17:0], 1'b1};
        end else begin
          rem_r[i] <= t[32:0];
          q_r[i]   <= {q_r[i-1][17:0], 1'b0};
        end
        ovf_r[i] <= ovf_r[i-1];
        lo_r[i]  <= lo_r[i-1];
        d_r[i]   <= d_r[i-1];
      end
    end
  end

  assign env = ovf_r[LAST] ? sbcm_pkg::ENV_MAX : {1'b0, q_r[LAST]};

endmodule

>>> design/sbcm_smooth_store.sv
// Per-bin smoothed modulator magnitude store with read-modify-write.
module sbcm_smooth_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sbcm_pkg::smooth_req_t req,
  output logic [31:0]           ymag,
  output logic                  busy
);

  logic [31:0] mem [sbcm_pkg::BIN_COUNT];

  logic                        clearing_r;
  logic [sbcm_pkg::ADDR_W-1:0] clr_addr_r;
  sbcm_pkg::smooth_req_t       b_r;
  logic [31:0]                 rd_r;
  logic                        fwd_vld_r;
  logic [sbcm_pkg::ADDR_W-1:0] fwd_addr_r;
  logic [31:0]                 fwd_val_r;
  logic [31:0]                 ymag_r;

  logic [31:0] s_old;
  logic [47:0] s_prod;
  logic [48:0] s_sum;
  logic [31:0] s_new;
  logic        wr_en;

  // The entry written on the previous beat is not yet in the read data.
  assign s_old  = (fwd_vld_r && fwd_addr_r == b_r.addr) ? fwd_val_r : rd_r;
  assign s_prod = s_old * sbcm_pkg::SMOOTH_B;
  assign s_sum  = {1'b0, s_prod} + {3'b000, b_r.mterm} + 49'd32768;
  assign s_new  = s_sum[47:16];
  assign wr_en  = en && b_r.vld;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[b_r.addr] <= s_new;
    end
    if (en) begin
      rd_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      b_r.vld    <= 1'b0;
      fwd_vld_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == sbcm_pkg::ADDR_W'(sbcm_pkg::BIN_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (en) begin
        b_r.vld   <= req.vld;
        b_r.addr  <= req.addr;
        b_r.mterm <= req.mterm;
        fwd_vld_r <= b_r.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr_r <= b_r.addr;
      fwd_val_r  <= s_new;
      ymag_r     <= s_new;
    end
  end

  assign ymag = ymag_r;
  assign busy = clearing_r;

endmodule

>>> tb/spectral_bin_cross_modulator_core_tb.sv
// Testbench for the spectral bin cross-modulator: directed and random bins checked against a bin-gain predictor.
module spectral_bin_cross_modulator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;

  class bin_gain_scoreboard;
    sbcm_pkg::out_beat_t expected_q[$];
    logic [31:0] smooth_mag[sbcm_pkg::BIN_COUNT];
    logic [2:0]  mode;
    logic [9:0]  band_lo;
    logic [9:0]  band_hi;
    int          errors;
    int          checked;
    int          in_band;

    function new();
      foreach (smooth_mag[k]) smooth_mag[k] = '0;
      mode    = sbcm_pkg::MODE_RING;
      band_lo = 10'd0;
      band_hi = 10'd460;
      errors  = 0;
      checked = 0;
      in_band = 0;
    endfunction

    function void write_reg(logic [sbcm_pkg::CFG_IDX_W-1:0] idx,
                            logic [sbcm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sbcm_pkg::REG_MODE:      mode = data[2:0];
        sbcm_pkg::REG_BAND_LOW:  band_lo = data;
        sbcm_pkg::REG_BAND_HIGH: band_hi = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_w;
      res   = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v   = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function logic [31:0] cmag(logic signed [31:0] re, logic signed [31:0] im);
      longint      r2;
      longint      i2;
      logic [63:0] m;
      r2 = longint'(re) * longint'(re);
      i2 = longint'(im) * longint'(im);
      m  = root_floor(64'(r2) + 64'(i2));
      return m[31:0];
    endfunction

    // round half up toward +inf, then clamp to signed 32 bits
    function logic signed [31:0] scale(logic signed [31:0] x, logic [31:0] gain);
      longint p;
      p = longint'(x) * longint'({32'd0, gain}) + 64'sd32768;
      p = p >>> 16;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    function void note_bin(sbcm_pkg::in_beat_t b);
      sbcm_pkg::out_beat_t r;
      logic [63:0] s;
      logic [31:0] ymag;
      logic [31:0] xmag;
      logic [63:0] e;
      logic [31:0] env;
      logic [31:0] gain;
      r.out_re = b.carrier_re;
      r.out_im = b.carrier_im;
      if (b.bin_index < sbcm_pkg::BIN_COUNT) begin
        s = 64'(smooth_mag[b.bin_index]) * 64'(sbcm_pkg::SMOOTH_B)
          + 64'(cmag(b.mod_re, b.mod_im)) * 64'(sbcm_pkg::SMOOTH_A) + 64'd32768;
        smooth_mag[b.bin_index] = s[47:16];
        ymag = smooth_mag[b.bin_index];
        if (b.bin_index >= band_lo && b.bin_index <= band_hi) begin
          in_band++;
          if (mode == sbcm_pkg::MODE_RING) begin
            gain = (ymag < 32'(sbcm_pkg::GAIN_ONE)) ? ymag : 32'(sbcm_pkg::GAIN_ONE);
          end else begin
            xmag = cmag(b.carrier_re, b.carrier_im);
            if (xmag == 0) begin
              env = 32'(sbcm_pkg::ENV_MAX);
            end else begin
              e   = {ymag, 16'd0} / xmag;
              env = (e > 64'(sbcm_pkg::ENV_MAX)) ? 32'(sbcm_pkg::ENV_MAX) : e[31:0];
            end
            case (mode)
              sbcm_pkg::MODE_AMP, sbcm_pkg::MODE_MIN:
                gain = (env < 32'(sbcm_pkg::GAIN_ONE)) ? env : 32'(sbcm_pkg::GAIN_ONE);
              sbcm_pkg::MODE_CROSS:
                gain = env;
              sbcm_pkg::MODE_AM:
                gain = (32'(sbcm_pkg::GAIN_ONE) + env > 32'(sbcm_pkg::ENV_MAX)) ?
                       32'(sbcm_pkg::ENV_MAX) : 32'(sbcm_pkg::GAIN_ONE) + env;
              sbcm_pkg::MODE_SUB:
                gain = (env < 32'(sbcm_pkg::GAIN_ONE)) ?
                       32'(sbcm_pkg::GAIN_ONE) - env : 32'd0;
              default:
                gain = 32'(sbcm_pkg::GAIN_ONE);
            endcase
          end
          r.out_re = scale(b.carrier_re, gain);
          r.out_im = scale(b.carrier_im, gain);
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_bin(sbcm_pkg::out_beat_t got);
      sbcm_pkg::out_beat_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected beat re=%h im=%h", got.out_re, got.out_im);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_re !== want.out_re || got.out_im !== want.out_im) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: beat %0d re exp %h got %h, im exp %h got %h",
                   checked, want.out_re, got.out_re, want.out_im, got.out_im);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  sbcm_pkg::in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  sbcm_pkg::out_beat_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [sbcm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sbcm_pkg::CFG_DATA_W-1:0] cfg_data;

  bin_gain_scoreboard sb;
  int  cycles;
  int  hold_left;
  bit  hold_req;
  bit  quiet;
  int  sent;

  spectral_bin_cross_modulator_core u_top (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 17);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_bin(out_data);
  end

  function logic signed [31:0] rand_q16();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: ;
      1: v = v >> $urandom_range(0, 31);
      2: case ($urandom_range(0, 4))
           0: v = 32'h7fffffff;
           1: v = 32'h80000000;
           2: v = 32'd0;
           3: v = 32'd1;
           default: v = 32'hffffffff;
         endcase
      default: begin
        v = v >> $urandom_range(12, 22);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function sbcm_pkg::in_beat_t rand_bin();
    sbcm_pkg::in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      b.bin_index = 10'($urandom_range(0, 7));
    else if (pick < 70) b.bin_index = (pick & 1) ? sb.band_lo : sb.band_hi;
    else if (pick < 90) b.bin_index = 10'($urandom_range(0, sbcm_pkg::BIN_COUNT - 1));
    else                b.bin_index = 10'($urandom_range(0, 1023));
    b.carrier_re = rand_q16();
    b.carrier_im = rand_q16();
    b.mod_re     = rand_q16();
    b.mod_im     = rand_q16();
    return b;
  endfunction

  task automatic send_bin(sbcm_pkg::in_beat_t b);
    if (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_bin(b);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbcm_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbcm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_up(logic [2:0] m, logic [9:0] lo, logic [9:0] hi);
    drain();
    write_reg(sbcm_pkg::REG_MODE, sbcm_pkg::CFG_DATA_W'(m));
    write_reg(sbcm_pkg::REG_BAND_LOW, lo);
    write_reg(sbcm_pkg::REG_BAND_HIGH, hi);
  endtask

  initial begin
    sbcm_pkg::in_beat_t b;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    out_stall = 1'b0;
    hold_req  = 1'b0;
    hold_left = 0;
    quiet     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each mode with zero carrier, full-scale carrier, and the store edges
    for (int m = 0; m < 8; m++) begin
      set_up(3'(m), 10'd0, 10'd512);
      b = '{10'd0, 32'sd0, 32'sd0, 32'h7fffffff, 32'h80000000};
      send_bin(b);
      b = '{10'd512, 32'h80000000, 32'h7fffffff, 32'h00020000, 32'hfffe0000};
      send_bin(b);
      b = '{10'd0, 32'h00010000, 32'hffff0000, 32'h00008000, 32'h00000001};
      send_bin(b);
    end
    b = '{10'd513, 32'h12345678, 32'h87654321, 32'h7fffffff, 32'h7fffffff};
    send_bin(b);
    // empty band with an unknown register written too
    set_up(3'(sbcm_pkg::MODE_CROSS), 10'd300, 10'd200);
    write_reg(2'd3, 10'h3ff);
    b = '{10'd250, 32'h00030000, 32'h00040000, 32'h00050000, 32'h0};
    send_bin(b);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       set_up(3'(sbcm_pkg::MODE_RING), 10'd0, 10'd512);
        1:       set_up(3'd7, 10'd1023, 10'd1023);
        2:       set_up(3'(sbcm_pkg::MODE_AM), 10'd512, 10'd0);
        default: set_up(3'($urandom_range(0, 7)), 10'($urandom_range(0, 4)),
                        ($urandom_range(0, 3) == 0) ? 10'd512 : 10'($urandom_range(3, 512)));
      endcase
      quiet = (ph == 5);
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 10) hold_req = 1'b1;
        if (ph == 7 && n == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send_bin(rand_bin());
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Run: %0d bins sent, %0d checked, %0d shaped in band, over all modes and bands.",
             sent, sb.checked, sb.in_band);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/sbcm_pkg.sv
design/sbcm_sqrt_pipe.sv
design/sbcm_div_pipe.sv
design/sbcm_smooth_store.sv
design/spectral_bin_cross_modulator_core.sv
tb/spectral_bin_cross_modulator_core_tb.sv
